/* rtl/elg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elg_pkg
// Shared types and codes of the ElGamal signature engine.
// ----------------------------------------------------------------------------
package elg_pkg;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GENERATOR  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECRET_KEY = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PUBLIC_KEY = 2'd3;

   localparam logic [1:0] MODE_KEYGEN = 2'd0;
   localparam logic [1:0] MODE_SIGN   = 2'd1;
   localparam logic [1:0] MODE_VERIFY = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] message;
      logic [31:0] session_key;
      logic [31:0] sig_a;
      logic [31:0] sig_b;
   } req_type;

   typedef struct packed {
      logic [31:0] result_a;
      logic [31:0] result_b;
      logic        sig_valid;
      logic        status;
   } rsp_type;

endpackage

/* rtl/elg_mulmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elg_mulmod
// Bit-serial modular multiplier: x * y mod m, one multiplier bit per cycle,
// msb first. With x = 1 mod m it reduces y mod m.
// ----------------------------------------------------------------------------
module elg_mulmod #(
   parameter int W  = 32,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [W-1:0]  x,
   input  logic [DW-1:0] y,
   input  logic [W-1:0]  m,
   output logic          done,
   output logic [W-1:0]  res
);
   localparam int CW = $clog2(DW + 1);

   logic [W-1:0]  acc_ff, acc_in, dbl;
   logic [W-1:0]  x_ff, m_ff;
   logic [DW-1:0] y_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;

   function automatic logic [W-1:0] add_m(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] md);
      logic [W-1:0] room;
      room = md - b;
      return (a >= room) ? (a - room) : (a + b);
   endfunction

   always_comb begin
      dbl    = add_m(acc_ff, acc_ff, m_ff);
      acc_in = y_ff[DW-1] ? add_m(dbl, x_ff, m_ff) : dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !go && busy_ff && (cnt_ff == CW'(1));
         if (go) begin
            busy_ff <= 1'b1;
            acc_ff  <= '0;
            x_ff    <= x;
            y_ff    <= y;
            m_ff    <= m;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            y_ff   <= {y_ff[DW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign res  = acc_ff;

endmodule

/* rtl/elg_divu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elg_divu
// Restoring divider: one quotient bit per cycle, gives quotient and remainder.
// ----------------------------------------------------------------------------
module elg_divu #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff, trial, rem_in;
   logic [W-1:0]  quo_ff, den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff, fit;

   always_comb begin
      trial  = {rem_ff[W-1:0], quo_ff[W-1]};
      fit    = trial >= {1'b0, den_ff};
      rem_in = fit ? (trial - {1'b0, den_ff}) : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !go && busy_ff && (cnt_ff == CW'(1));
         if (go) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[W-2:0], fit};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff[W-1:0];

endmodule

/* rtl/elgamal_signature_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_signature_engine
// ElGamal key generation, signing and verification over a configured prime.
// ----------------------------------------------------------------------------
// cost: every modular product runs in the one shared bit-serial multiplier;
// a power takes up to 1 + 64 products, so key generation is one power, verify
// three powers and one product, sign adds up to ~47 euclid steps of one
// division and one product each
// throughput: one beat at a time, next beat taken once the result is queued
// reset: synchronous, sets modulus 3, generator 2, secret key 0, public key 1
module elgamal_signature_engine #(
   parameter int MOD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  elg_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output elg_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [elg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [elg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import elg_pkg::*;

   localparam int W  = MOD_BITS;
   localparam int DW = (MOD_BITS > 32) ? MOD_BITS : 32;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_MUL_WAIT,
      ST_POW_INIT, ST_POW_B0, ST_POW_LOOP, ST_POW_R, ST_POW_SQ,
      ST_KG_END,
      ST_INV_START, ST_INV_LOOP, ST_INV_DIV, ST_INV_T, ST_INV_END,
      ST_SG_A, ST_SG_X, ST_SG_AN, ST_SG_XA, ST_SG_M, ST_SG_B,
      ST_VF_1, ST_VF_2, ST_VF_3, ST_VF_4,
      ST_DONE
   } state_type;

   state_type state_ff, ret_ff, pret_ff;

   logic [31:0]   modulus_ff, generator_ff, secret_ff, public_ff;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic [W-1:0]  p, n, one_n, tsub;
   logic [DW-1:0] mod_dw;

   logic [W-1:0]  pr_ff, pb_ff, u_ff, v_ff;
   logic [DW-1:0] pbase_ff, ra_ff, rb_ff;
   logic [31:0]   pe_ff;
   logic [W-1:0]  r0_ff, r1_ff, t0_ff, t1_ff;
   logic          valid_ff, status_ff;

   logic          mul_go_ff, mul_done, mul_start;
   logic [W-1:0]  mul_x_ff, mul_m_ff, mul_res;
   logic [DW-1:0] mul_y_ff;

   logic          div_go_ff, div_done, div_start;
   logic [W-1:0]  div_quo, div_rem;

   function automatic logic [W-1:0] sub_m(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] md);
      return (a >= b) ? (a - b) : (a + (md - b));
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= 32'd3;
         generator_ff <= 32'd2;
         secret_ff    <= 32'd0;
         public_ff    <= 32'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODULUS:    modulus_ff   <= csr_wdata;
            CSR_GENERATOR:  generator_ff <= csr_wdata;
            CSR_SECRET_KEY: secret_ff    <= csr_wdata;
            CSR_PUBLIC_KEY: public_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mod_dw = DW'(modulus_ff);
      p      = mod_dw[W-1:0];
      n      = p - 1'b1;
      one_n  = W'(n != W'(1));
      tsub   = sub_m(mul_res, v_ff, n);
   end

   // states that launch a product or a division
   always_comb begin
      unique case (state_ff)
         ST_DISPATCH:  mul_start = (req_ff.mode == MODE_SIGN) && (p >= W'(2));
         ST_POW_INIT, ST_POW_R, ST_SG_A, ST_SG_X, ST_SG_AN, ST_SG_XA, ST_SG_M, ST_VF_2:
                       mul_start = 1'b1;
         ST_POW_LOOP:  mul_start = (pe_ff != 32'd0);
         ST_INV_DIV:   mul_start = div_done;
         default:      mul_start = 1'b0;
      endcase
      div_start = (state_ff == ST_INV_LOOP) && (r1_ff != '0);
   end

   elg_mulmod #(.W(W), .DW(DW)) u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go_ff),
      .x     (mul_x_ff),
      .y     (mul_y_ff),
      .m     (mul_m_ff),
      .done  (mul_done),
      .res   (mul_res)
   );

   elg_divu #(.W(W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (r0_ff),
      .den   (r1_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pret_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         mul_go_ff <= mul_start;
         div_go_ff <= div_start;
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  ra_ff     <= '0;
                  rb_ff     <= '0;
                  valid_ff  <= 1'b0;
                  status_ff <= 1'b0;
                  state_ff  <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               unique case (req_ff.mode)
                  MODE_KEYGEN: begin
                     if (p < W'(2)) begin
                        state_ff <= ST_DONE;
                     end else begin
                        pbase_ff <= DW'(generator_ff);
                        pe_ff    <= secret_ff;
                        pret_ff  <= ST_KG_END;
                        state_ff <= ST_POW_INIT;
                     end
                  end
                  MODE_SIGN: begin
                     if (p < W'(2)) begin
                        status_ff <= 1'b1;
                        state_ff  <= ST_DONE;
                     end else begin
                        mul_x_ff  <= one_n;
                        mul_y_ff  <= DW'(req_ff.session_key);
                        mul_m_ff  <= n;
                        ret_ff    <= ST_INV_START;
                        state_ff  <= ST_MUL_WAIT;
                     end
                  end
                  MODE_VERIFY: begin
                     if (p < W'(2)) begin
                        state_ff <= ST_DONE;
                     end else begin
                        pbase_ff <= DW'(public_ff);
                        pe_ff    <= req_ff.sig_a;
                        pret_ff  <= ST_VF_1;
                        state_ff <= ST_POW_INIT;
                     end
                  end
                  MODE_UNUSED: state_ff <= ST_DONE;
                  default:     state_ff <= ST_DONE;
               endcase
            end
            ST_MUL_WAIT: begin
               if (mul_done) begin
                  state_ff <= ret_ff;
               end
            end
            // power mod p: base in pbase_ff, exponent in pe_ff
            ST_POW_INIT: begin
               mul_x_ff  <= W'(1);
               mul_y_ff  <= pbase_ff;
               mul_m_ff  <= p;
               ret_ff    <= ST_POW_B0;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_POW_B0: begin
               pb_ff    <= mul_res;
               pr_ff    <= W'(1);
               state_ff <= ST_POW_LOOP;
            end
            ST_POW_LOOP: begin
               mul_m_ff <= p;
               if (pe_ff == 32'd0) begin
                  state_ff <= pret_ff;
               end else begin
                  mul_x_ff  <= pe_ff[0] ? pr_ff : pb_ff;
                  mul_y_ff  <= DW'(pb_ff);
                  ret_ff    <= pe_ff[0] ? ST_POW_R : ST_POW_SQ;
                  state_ff  <= ST_MUL_WAIT;
               end
            end
            ST_POW_R: begin
               pr_ff     <= mul_res;
               mul_x_ff  <= pb_ff;
               mul_y_ff  <= DW'(pb_ff);
               ret_ff    <= ST_POW_SQ;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_POW_SQ: begin
               pb_ff    <= mul_res;
               pe_ff    <= {1'b0, pe_ff[31:1]};
               state_ff <= ST_POW_LOOP;
            end
            ST_KG_END: begin
               ra_ff    <= DW'(pr_ff);
               state_ff <= ST_DONE;
            end
            // extended euclid for the inverse of k mod p-1
            ST_INV_START: begin
               r0_ff    <= n;
               r1_ff    <= mul_res;
               t0_ff    <= '0;
               t1_ff    <= one_n;
               state_ff <= ST_INV_LOOP;
            end
            ST_INV_LOOP: begin
               if (r1_ff == '0) begin
                  state_ff <= ST_INV_END;
               end else begin
                  state_ff  <= ST_INV_DIV;
               end
            end
            ST_INV_DIV: begin
               if (div_done) begin
                  mul_x_ff  <= t1_ff;
                  mul_y_ff  <= DW'(div_quo);
                  mul_m_ff  <= n;
                  ret_ff    <= ST_INV_T;
                  state_ff  <= ST_MUL_WAIT;
               end
            end
            ST_INV_T: begin
               t1_ff    <= sub_m(t0_ff, mul_res, n);
               t0_ff    <= t1_ff;
               r0_ff    <= r1_ff;
               r1_ff    <= div_rem;
               state_ff <= ST_INV_LOOP;
            end
            ST_INV_END: begin
               if (r0_ff != W'(1)) begin
                  status_ff <= 1'b1;
                  state_ff  <= ST_DONE;
               end else begin
                  pbase_ff <= DW'(generator_ff);
                  pe_ff    <= req_ff.session_key;
                  pret_ff  <= ST_SG_A;
                  state_ff <= ST_POW_INIT;
               end
            end
            // b = (m - x*a) * kinv mod p-1
            ST_SG_A: begin
               ra_ff     <= DW'(pr_ff);
               mul_x_ff  <= one_n;
               mul_y_ff  <= DW'(secret_ff);
               mul_m_ff  <= n;
               ret_ff    <= ST_SG_X;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_SG_X: begin
               u_ff      <= mul_res;
               mul_x_ff  <= one_n;
               mul_y_ff  <= DW'(pr_ff);
               ret_ff    <= ST_SG_AN;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_SG_AN: begin
               mul_x_ff  <= u_ff;
               mul_y_ff  <= DW'(mul_res);
               ret_ff    <= ST_SG_XA;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_SG_XA: begin
               v_ff      <= mul_res;
               mul_x_ff  <= one_n;
               mul_y_ff  <= DW'(req_ff.message);
               ret_ff    <= ST_SG_M;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_SG_M: begin
               mul_x_ff  <= tsub;
               mul_y_ff  <= DW'(t0_ff);
               ret_ff    <= ST_SG_B;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_SG_B: begin
               rb_ff    <= DW'(mul_res);
               state_ff <= ST_DONE;
            end
            // y^a * a^b against g^m
            ST_VF_1: begin
               u_ff     <= pr_ff;
               pbase_ff <= DW'(req_ff.sig_a);
               pe_ff    <= req_ff.sig_b;
               pret_ff  <= ST_VF_2;
               state_ff <= ST_POW_INIT;
            end
            ST_VF_2: begin
               mul_x_ff  <= u_ff;
               mul_y_ff  <= DW'(pr_ff);
               mul_m_ff  <= p;
               ret_ff    <= ST_VF_3;
               state_ff  <= ST_MUL_WAIT;
            end
            ST_VF_3: begin
               v_ff     <= mul_res;
               pbase_ff <= DW'(generator_ff);
               pe_ff    <= req_ff.message;
               pret_ff  <= ST_VF_4;
               state_ff <= ST_POW_INIT;
            end
            ST_VF_4: begin
               valid_ff <= (v_ff == pr_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.result_a  <= ra_ff[31:0];
                  rsp_ff.result_b  <= rb_ff[31:0];
                  rsp_ff.sig_valid <= valid_ff;
                  rsp_ff.status    <= status_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/elg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elg_checker
// Port-level checks of the ElGamal signature engine, bound to the top level.
// ----------------------------------------------------------------------------
module elg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input elg_pkg::rsp_type rsp_data
);
   import elg_pkg::*;

   // held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // engine is busy right after taking a beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine ready right after accepting a beat");

   // bad session key or modulus gives no signature
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.result_a == 32'd0 && rsp_data.result_b == 32'd0 && !rsp_data.sig_valid)
      else $error("status set with nonzero results");

   // passing verify carries no other result
   a_valid_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sig_valid |->
         rsp_data.result_a == 32'd0 && rsp_data.result_b == 32'd0 && !rsp_data.status)
      else $error("verify beat with stray results");

endmodule

bind elgamal_signature_engine elg_checker u_elg_checker (.*);
